@@ src/lbpwf_pkg.sv @@
package lbpwf_pkg;

  localparam int CNT_W = 4;

  // operation codes
  localparam logic OP_WINDOW = 1'b0;
  localparam logic OP_PIXEL  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_BUS_IF    = 2'd0;
  localparam logic [1:0] CFG_PIX_FMT   = 2'd1;
  localparam logic [1:0] CFG_XFER_MODE = 2'd2;

  // bus interface codes
  localparam logic [2:0] BUS_I8   = 3'd0;
  localparam logic [2:0] BUS_I16  = 3'd1;
  localparam logic [2:0] BUS_I9   = 3'd2;
  localparam logic [2:0] BUS_I18  = 3'd3;
  localparam logic [2:0] BUS_II8  = 3'd4;
  localparam logic [2:0] BUS_II16 = 3'd5;
  localparam logic [2:0] BUS_II9  = 3'd6;
  localparam logic [2:0] BUS_II18 = 3'd7;

  // transfer modes
  localparam logic [1:0] XFER_M0 = 2'd0;
  localparam logic [1:0] XFER_M1 = 2'd1;
  localparam logic [1:0] XFER_M2 = 2'd2;
  localparam logic [1:0] XFER_M3 = 2'd3;

  // display commands
  localparam logic [7:0] CMD_COL_ADDR  = 8'h2A;
  localparam logic [7:0] CMD_PAGE_ADDR = 8'h2B;
  localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;

  // word counts
  localparam logic [CNT_W-1:0] WIN_WORDS = 4'd11;

  typedef struct packed {
    logic        operation;
    logic [8:0]  x_start;
    logic [8:0]  y_start;
    logic [8:0]  x_end;
    logic [8:0]  y_end;
    logic [23:0] color;
  } in_item_t;

  typedef struct packed {
    logic [17:0] bus_word;
    logic        is_command;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [2:0] bus_interface;
    logic       pixel_format_18bit;
    logic [1:0] transfer_mode;
  } cfg_t;

endpackage

@@ src/lbpwf_pack.sv @@
module lbpwf_pack #(
  parameter int COORD_BITS = 9
) (
  input  lbpwf_pkg::in_item_t              item,
  input  lbpwf_pkg::cfg_t                  cfg,
  input  logic [lbpwf_pkg::CNT_W-1:0]      idx,
  output lbpwf_pkg::out_item_t             word,
  output logic [lbpwf_pkg::CNT_W-1:0]      cnt
);

  localparam logic [15:0] COORD_MASK = 16'(((32'd1 << COORD_BITS) - 32'd1) & 32'hFFFF);

  logic [3:0]  sh;
  logic [15:0] xs, ys, xe, ye;
  logic [7:0]  wbyte;
  logic        wcmd;
  logic [17:0] win_word;
  logic [31:0] c;
  logic [31:0] w0, w1, w2;
  logic [lbpwf_pkg::CNT_W-1:0] pix_cnt;
  logic [31:0] pix_word;
  logic        f18;
  logic [1:0]  m;

  assign xs = {7'd0, item.x_start} & COORD_MASK;
  assign ys = {7'd0, item.y_start} & COORD_MASK;
  assign xe = {7'd0, item.x_end} & COORD_MASK;
  assign ye = {7'd0, item.y_end} & COORD_MASK;

  // command and parameter lane position on the bus
  always_comb begin
    case (cfg.bus_interface)
      lbpwf_pkg::BUS_II8, lbpwf_pkg::BUS_II9:   sh = 4'd10;
      lbpwf_pkg::BUS_II16, lbpwf_pkg::BUS_II18: sh = 4'd1;
      default:                                  sh = 4'd0;
    endcase
  end

  always_comb begin
    wcmd = 1'b0;
    case (idx)
      4'd0: begin
        wbyte = lbpwf_pkg::CMD_COL_ADDR;
        wcmd  = 1'b1;
      end
      4'd1: wbyte = xs[15:8];
      4'd2: wbyte = xs[7:0];
      4'd3: wbyte = xe[15:8];
      4'd4: wbyte = xe[7:0];
      4'd5: begin
        wbyte = lbpwf_pkg::CMD_PAGE_ADDR;
        wcmd  = 1'b1;
      end
      4'd6: wbyte = ys[15:8];
      4'd7: wbyte = ys[7:0];
      4'd8: wbyte = ye[15:8];
      4'd9: wbyte = ye[7:0];
      4'd10: begin
        wbyte = lbpwf_pkg::CMD_MEM_WRITE;
        wcmd  = 1'b1;
      end
      default: wbyte = 8'd0;
    endcase
  end

  assign win_word = {10'd0, wbyte} << sh;

  assign c   = {8'd0, item.color};
  assign f18 = cfg.pixel_format_18bit;
  assign m   = cfg.transfer_mode;

  always_comb begin
    w0 = 32'd0;
    w1 = 32'd0;
    w2 = 32'd0;
    pix_cnt = 4'd0;
    case (cfg.bus_interface)
      lbpwf_pkg::BUS_I8: begin
        if (!f18) begin
          w0 = ((c & 32'hF80000) >> 16) | ((c & 32'h00E000) >> 13);
          w1 = ((c & 32'h001C00) >> 5) | ((c & 32'h0000F8) >> 3);
          pix_cnt = 4'd2;
        end else begin
          w0 = (c & 32'hFC0000) >> 16;
          w1 = (c & 32'h00FC00) >> 8;
          w2 = c & 32'h0000FC;
          pix_cnt = 4'd3;
        end
      end
      lbpwf_pkg::BUS_I16: begin
        if (!f18) begin
          w0 = ((c & 32'hF80000) >> 8) | ((c & 32'h00FC00) >> 5) | ((c & 32'h0000F8) >> 3);
          pix_cnt = 4'd1;
        end else if (m == lbpwf_pkg::XFER_M1) begin
          w0 = (c & 32'hFCFC00) >> 8;
          w1 = (c & 32'h0000FC) << 8;
          pix_cnt = 4'd2;
        end else if (m == lbpwf_pkg::XFER_M2) begin
          w0 = ((c & 32'hFC0000) >> 8) | ((c & 32'h00FC00) >> 6) | ((c & 32'h0000F0) >> 4);
          w1 = (c & 32'h000003) << 14;
          pix_cnt = 4'd2;
        end else if (m == lbpwf_pkg::XFER_M3) begin
          w0 = (c & 32'hC00000) >> 22;
          w1 = ((c & 32'h3C0000) >> 6) | ((c & 32'h00FC00) >> 4) | ((c & 32'h0000FC) >> 2);
          pix_cnt = 4'd2;
        end
      end
      lbpwf_pkg::BUS_I9: begin
        if (!f18) begin
          w0 = ((c & 32'hF80000) >> 16) | ((c & 32'h00E000) >> 13);
          w1 = ((c & 32'h001C00) >> 5) | ((c & 32'h0000F8) >> 3);
          pix_cnt = 4'd2;
        end else if (m == lbpwf_pkg::XFER_M0) begin
          w0 = ((c & 32'hFC0000) >> 15) | ((c & 32'h00E000) >> 13);
          w1 = ((c & 32'h001C00) >> 4) | ((c & 32'h0000FC) >> 2);
          pix_cnt = 4'd2;
        end else if (m == lbpwf_pkg::XFER_M1) begin
          w0 = (c & 32'hFC0000) >> 16;
          w1 = (c & 32'h00FC00) >> 8;
          w2 = c & 32'h0000FC;
          pix_cnt = 4'd3;
        end
      end
      lbpwf_pkg::BUS_I18, lbpwf_pkg::BUS_II18: begin
        if (!f18) begin
          w0 = ((c & 32'hF80000) >> 8) | ((c & 32'h00FC00) >> 5) | ((c & 32'h0000F8) >> 3);
        end else begin
          w0 = ((c & 32'hFC0000) >> 6) | ((c & 32'h00FC00) >> 4) | ((c & 32'h0000FC) >> 2);
        end
        pix_cnt = 4'd1;
      end
      lbpwf_pkg::BUS_II8: begin
        if (!f18) begin
          w0 = ((c & 32'hF80000) >> 6) | ((c & 32'h00E000) >> 3);
          w1 = ((c & 32'h001C00) << 5) | ((c & 32'h0000F8) << 7);
          pix_cnt = 4'd2;
        end else begin
          w0 = (c & 32'hFC0000) >> 6;
          w1 = (c & 32'h00FC00) << 2;
          w2 = (c & 32'h0000FC) << 10;
          pix_cnt = 4'd3;
        end
      end
      lbpwf_pkg::BUS_II16: begin
        if (!f18) begin
          w0 = ((c & 32'hF80000) >> 6) | ((c & 32'h00E000) >> 3) | (c & 32'h001C00)
             | ((c & 32'h0000F8) >> 2);
          pix_cnt = 4'd1;
        end else if (m == lbpwf_pkg::XFER_M1) begin
          w0 = ((c & 32'hFC0000) >> 6) | ((c & 32'h00FC00) >> 7);
          w1 = (c & 32'h0000FC) << 10;
          pix_cnt = 4'd2;
        end else if (m == lbpwf_pkg::XFER_M2) begin
          w0 = ((c & 32'hFC0000) >> 6) | ((c & 32'h00C000) >> 4) | ((c & 32'h003C00) >> 5)
             | ((c & 32'h0000F0) >> 3);
          w1 = (c & 32'h000003) << 16;
          pix_cnt = 4'd2;
        end else if (m == lbpwf_pkg::XFER_M3) begin
          w0 = (c & 32'hC00000) >> 16;
          w1 = ((c & 32'h3C0000) >> 4) | ((c & 32'h00F000) >> 2) | ((c & 32'h000C00) >> 3)
             | ((c & 32'h0000FC) >> 2);
          pix_cnt = 4'd2;
        end
      end
      lbpwf_pkg::BUS_II9: begin
        if (!f18) begin
          w0 = ((c & 32'hF80000) >> 7) | ((c & 32'h00E000) >> 4);
          w1 = ((c & 32'h001C00) << 4) | ((c & 32'h0000F8) << 6);
          pix_cnt = 4'd2;
        end else if (m == lbpwf_pkg::XFER_M0) begin
          w0 = ((c & 32'hFC0000) >> 6) | ((c & 32'h00E000) >> 4);
          w1 = ((c & 32'h001C00) << 5) | ((c & 32'h0000FC) << 7);
          pix_cnt = 4'd2;
        end else if (m == lbpwf_pkg::XFER_M1) begin
          w0 = (c & 32'hFC0000) >> 7;
          w1 = (c & 32'h00FC00) << 1;
          w2 = (c & 32'h0000FC) << 9;
          pix_cnt = 4'd3;
        end
      end
      default: pix_cnt = 4'd0;
    endcase
  end

  always_comb begin
    case (idx)
      4'd0:    pix_word = w0;
      4'd1:    pix_word = w1;
      4'd2:    pix_word = w2;
      default: pix_word = 32'd0;
    endcase
  end

  always_comb begin
    if (item.operation == lbpwf_pkg::OP_WINDOW) begin
      cnt             = lbpwf_pkg::WIN_WORDS;
      word.bus_word   = win_word;
      word.is_command = wcmd;
    end else begin
      cnt             = pix_cnt;
      word.bus_word   = pix_word[17:0];
      word.is_command = 1'b0;
    end
    word.last = (cnt != '0) && (idx + 4'd1 == cnt);
  end

endmodule

@@ src/lcd_bus_pixel_window_formatter_unit.sv @@
// Formats window and pixel requests into the word stream of an MCU parallel display bus.
// A request is held in an input register and its words are built from it one at a time into
// a single output word register, so the block puts out at most one bus word per cycle while
// out_stall is low. A window request gives 11 words, a pixel request 0 to 3 depending on bus
// interface, pixel format and transfer mode; one with no words leaves without using the output
// register. The next request is taken in the same cycle that the last word of the current one
// enters the output register. Configuration is written through the cfg port, which is always
// ready, while the block is idle: the user must keep to this, as the block does not enforce it.
module lcd_bus_pixel_window_formatter_unit #(
  parameter int COORD_BITS = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lbpwf_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lbpwf_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [2:0]           cfg_wdata
);

  lbpwf_pkg::cfg_t      cfg_r, cfg_nxt;
  lbpwf_pkg::in_item_t  hold_r, hold_nxt;
  logic                 hold_vld_r, hold_vld_nxt;
  logic [lbpwf_pkg::CNT_W-1:0] idx_r, idx_nxt;
  lbpwf_pkg::out_item_t out_r, out_nxt;
  logic                 out_vld_r, out_vld_nxt;

  lbpwf_pkg::out_item_t pk_word;
  logic [lbpwf_pkg::CNT_W-1:0] pk_cnt;
  logic out_free, item_empty, step, item_done, in_acc, out_load;

  lbpwf_pack #(
    .COORD_BITS(COORD_BITS)
  ) u_pack (
    .item(hold_r),
    .cfg (cfg_r),
    .idx (idx_r),
    .word(pk_word),
    .cnt (pk_cnt)
  );

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lbpwf_pkg::CFG_BUS_IF:    cfg_nxt.bus_interface      = cfg_wdata;
        lbpwf_pkg::CFG_PIX_FMT:   cfg_nxt.pixel_format_18bit = cfg_wdata[0];
        lbpwf_pkg::CFG_XFER_MODE: cfg_nxt.transfer_mode      = cfg_wdata[1:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  assign out_free   = !out_vld_r || !out_stall;
  assign item_empty = (pk_cnt == '0);
  assign step       = hold_vld_r && (item_empty || out_free);
  // an item with no words drains without touching the output register
  assign item_done  = step && (item_empty || pk_word.last);
  assign out_load   = step && !item_empty;
  assign in_stall   = hold_vld_r && !item_done;
  assign in_acc     = in_valid && !in_stall;

  always_comb begin
    hold_nxt     = in_acc ? in_data : hold_r;
    hold_vld_nxt = in_acc ? 1'b1 : (item_done ? 1'b0 : hold_vld_r);
    if (item_done) begin
      idx_nxt = '0;
    end else if (out_load) begin
      idx_nxt = idx_r + 4'd1;
    end else begin
      idx_nxt = idx_r;
    end
    out_nxt = out_load ? pk_word : out_r;
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r      <= '0;
      hold_vld_r <= 1'b0;
      idx_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      cfg_r      <= cfg_nxt;
      hold_vld_r <= hold_vld_nxt;
      idx_r      <= idx_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_idx_idle : assert property (@(posedge clk) disable iff (!rst_n)
    !hold_vld_r |-> idx_r == '0)
    else $error("word index not cleared without a held request");

  a_idx_range : assert property (@(posedge clk) disable iff (!rst_n)
    hold_vld_r && pk_cnt != '0 |-> idx_r < pk_cnt)
    else $error("word index past word count");

  a_take_on_done : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && hold_vld_r |-> item_done)
    else $error("request taken while current one unfinished");

  a_cmd_window : assert property (@(posedge clk) disable iff (!rst_n)
    out_load && pk_word.is_command |-> hold_r.operation == lbpwf_pkg::OP_WINDOW)
    else $error("command word from pixel request");

  a_last_loaded : assert property (@(posedge clk) disable iff (!rst_n)
    out_load && pk_word.last |=> !hold_vld_r || idx_r == '0)
    else $error("index not restarted after last word");

endmodule

@@ verif/lcd_bus_word_checker.sv @@
module lcd_bus_word_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  lbpwf_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  lbpwf_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [2:0]           cfg_wdata,
  output int                   fail_count,
  output int                   words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the configuration registers
  logic [2:0] bus_if = lbpwf_pkg::BUS_I8;
  logic       pix18  = 1'b0;
  logic [1:0] mode   = lbpwf_pkg::XFER_M0;

  lbpwf_pkg::out_item_t expected_words[$];
  int                   mismatches = 0;

  function automatic void push_word(input logic [31:0] w, input logic cmd, input logic fin);
    lbpwf_pkg::out_item_t o;
    o.bus_word   = w[17:0];
    o.is_command = cmd;
    o.last       = fin;
    expected_words.push_back(o);
  endfunction

  function automatic void push_addr(input logic [7:0] cmd, input logic [8:0] a,
                                    input logic [8:0] b, input int sh);
    push_word(32'(cmd) << sh, 1'b1, 1'b0);
    push_word(32'(a[8]) << sh, 1'b0, 1'b0);
    push_word(32'(a[7:0]) << sh, 1'b0, 1'b0);
    push_word(32'(b[8]) << sh, 1'b0, 1'b0);
    push_word(32'(b[7:0]) << sh, 1'b0, 1'b0);
  endfunction

  // expected bus words for one request under the current configuration
  function automatic void format_request(input lbpwf_pkg::in_item_t r);
    logic [31:0] c, w0, w1, w2;
    int          n, sh;
    c  = {8'h00, r.color};
    w0 = '0;
    w1 = '0;
    w2 = '0;
    n  = 0;
    if (r.operation == lbpwf_pkg::OP_WINDOW) begin
      if (bus_if == lbpwf_pkg::BUS_II8 || bus_if == lbpwf_pkg::BUS_II9) sh = 10;
      else if (bus_if == lbpwf_pkg::BUS_II16 || bus_if == lbpwf_pkg::BUS_II18) sh = 1;
      else sh = 0;
      push_addr(lbpwf_pkg::CMD_COL_ADDR, r.x_start, r.x_end, sh);
      push_addr(lbpwf_pkg::CMD_PAGE_ADDR, r.y_start, r.y_end, sh);
      push_word(32'(lbpwf_pkg::CMD_MEM_WRITE) << sh, 1'b1, 1'b1);
      return;
    end
    case (bus_if)
      lbpwf_pkg::BUS_I8, lbpwf_pkg::BUS_I9: begin
        if (!pix18) begin
          w0 = ((c & 32'hF80000) >> 16) | ((c & 32'h00E000) >> 13);
          w1 = ((c & 32'h001C00) >> 5) | ((c & 32'h0000F8) >> 3);
          n  = 2;
        end else if (bus_if == lbpwf_pkg::BUS_I8 || mode == lbpwf_pkg::XFER_M1) begin
          w0 = (c & 32'hFC0000) >> 16;
          w1 = (c & 32'h00FC00) >> 8;
          w2 = c & 32'h0000FC;
          n  = 3;
        end else if (mode == lbpwf_pkg::XFER_M0) begin
          w0 = ((c & 32'hFC0000) >> 15) | ((c & 32'h00E000) >> 13);
          w1 = ((c & 32'h001C00) >> 4) | ((c & 32'h0000FC) >> 2);
          n  = 2;
        end
      end
      lbpwf_pkg::BUS_I16, lbpwf_pkg::BUS_I18, lbpwf_pkg::BUS_II18: begin
        if (!pix18) begin
          w0 = ((c & 32'hF80000) >> 8) | ((c & 32'h00FC00) >> 5) | ((c & 32'h0000F8) >> 3);
          n  = 1;
        end else if (bus_if != lbpwf_pkg::BUS_I16) begin
          w0 = ((c & 32'hFC0000) >> 6) | ((c & 32'h00FC00) >> 4) | ((c & 32'h0000FC) >> 2);
          n  = 1;
        end else begin
          case (mode)
            lbpwf_pkg::XFER_M1: begin
              w0 = (c & 32'hFCFC00) >> 8;
              w1 = (c & 32'h0000FC) << 8;
              n  = 2;
            end
            lbpwf_pkg::XFER_M2: begin
              w0 = ((c & 32'hFC0000) >> 8) | ((c & 32'h00FC00) >> 6) | ((c & 32'h0000F0) >> 4);
              w1 = (c & 32'h000003) << 14;
              n  = 2;
            end
            lbpwf_pkg::XFER_M3: begin
              w0 = (c & 32'hC00000) >> 22;
              w1 = ((c & 32'h3C0000) >> 6) | ((c & 32'h00FC00) >> 4) |
                   ((c & 32'h0000FC) >> 2);
              n  = 2;
            end
            default: n = 0;
          endcase
        end
      end
      lbpwf_pkg::BUS_II8: begin
        if (!pix18) begin
          w0 = ((c & 32'hF80000) >> 6) | ((c & 32'h00E000) >> 3);
          w1 = ((c & 32'h001C00) << 5) | ((c & 32'h0000F8) << 7);
          n  = 2;
        end else begin
          w0 = (c & 32'hFC0000) >> 6;
          w1 = (c & 32'h00FC00) << 2;
          w2 = (c & 32'h0000FC) << 10;
          n  = 3;
        end
      end
      lbpwf_pkg::BUS_II16: begin
        if (!pix18) begin
          w0 = ((c & 32'hF80000) >> 6) | ((c & 32'h00E000) >> 3) | (c & 32'h001C00) |
               ((c & 32'h0000F8) >> 2);
          n  = 1;
        end else begin
          case (mode)
            lbpwf_pkg::XFER_M1: begin
              w0 = ((c & 32'hFC0000) >> 6) | ((c & 32'h00FC00) >> 7);
              w1 = (c & 32'h0000FC) << 10;
              n  = 2;
            end
            lbpwf_pkg::XFER_M2: begin
              w0 = ((c & 32'hFC0000) >> 6) | ((c & 32'h00C000) >> 4) |
                   ((c & 32'h003C00) >> 5) | ((c & 32'h0000F0) >> 3);
              w1 = (c & 32'h000003) << 16;
              n  = 2;
            end
            lbpwf_pkg::XFER_M3: begin
              w0 = (c & 32'hC00000) >> 16;
              w1 = ((c & 32'h3C0000) >> 4) | ((c & 32'h00F000) >> 2) |
                   ((c & 32'h000C00) >> 3) | ((c & 32'h0000FC) >> 2);
              n  = 2;
            end
            default: n = 0;
          endcase
        end
      end
      default: begin
        // type II nine-bit bus
        if (!pix18) begin
          w0 = ((c & 32'hF80000) >> 7) | ((c & 32'h00E000) >> 4);
          w1 = ((c & 32'h001C00) << 4) | ((c & 32'h0000F8) << 6);
          n  = 2;
        end else if (mode == lbpwf_pkg::XFER_M0) begin
          w0 = ((c & 32'hFC0000) >> 6) | ((c & 32'h00E000) >> 4);
          w1 = ((c & 32'h001C00) << 5) | ((c & 32'h0000FC) << 7);
          n  = 2;
        end else if (mode == lbpwf_pkg::XFER_M1) begin
          w0 = (c & 32'hFC0000) >> 7;
          w1 = (c & 32'h00FC00) << 1;
          w2 = (c & 32'h0000FC) << 9;
          n  = 3;
        end
      end
    endcase
    for (int i = 0; i < n; i++)
      push_word((i == 0) ? w0 : (i == 1) ? w1 : w2, 1'b0, i == n - 1);
  endfunction

  always @(posedge clk) begin
    lbpwf_pkg::out_item_t want;
    if (!rst_n) begin
      bus_if = lbpwf_pkg::BUS_I8;
      pix18  = 1'b0;
      mode   = lbpwf_pkg::XFER_M0;
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lbpwf_pkg::CFG_BUS_IF:    bus_if = cfg_wdata;
          lbpwf_pkg::CFG_PIX_FMT:   pix18  = cfg_wdata[0];
          lbpwf_pkg::CFG_XFER_MODE: mode   = cfg_wdata[1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected bus word, expected none, got %h cmd %b last %b",
                   $time, out_data.bus_word, out_data.is_command, out_data.last);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (out_data.bus_word !== want.bus_word) begin
            $display("%0t: bus_word expected %h, got %h",
                     $time, want.bus_word, out_data.bus_word);
            mismatches++;
          end
          if (out_data.is_command !== want.is_command) begin
            $display("%0t: is_command expected %b, got %b",
                     $time, want.is_command, out_data.is_command);
            mismatches++;
          end
          if (out_data.last !== want.last) begin
            $display("%0t: last expected %b, got %b", $time, want.last, out_data.last);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) format_request(in_data);
    end
    fail_count    <= mismatches;
    words_pending <= expected_words.size();
  end

endmodule

@@ verif/lcd_bus_pixel_window_formatter_unit_tb.sv @@
module lcd_bus_pixel_window_formatter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 240;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  lbpwf_pkg::in_item_t  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  lbpwf_pkg::out_item_t out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index = lbpwf_pkg::CFG_BUS_IF;
  logic [2:0]           cfg_wdata = '0;

  int fail_count;
  int words_pending;
  int cycles    = 0;
  int hold      = 0;
  bit no_idle   = 1'b0;

  lcd_bus_pixel_window_formatter_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lcd_bus_word_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 7);
  endfunction

  // receiver may stall after each word it takes, for a random gap drawn by draw_gap
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      hold = draw_gap();
      out_stall <= (hold != 0);
    end else if (out_stall) begin
      hold--;
      out_stall <= (hold != 0);
    end
  end

  function automatic logic [8:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return 9'($urandom);
    endcase
  endfunction

  function automatic lbpwf_pkg::in_item_t rand_request();
    lbpwf_pkg::in_item_t r;
    r.operation = $urandom_range(0, 1) ? lbpwf_pkg::OP_PIXEL : lbpwf_pkg::OP_WINDOW;
    r.x_start   = pick_coord();
    r.y_start   = pick_coord();
    r.x_end     = pick_coord();
    r.y_end     = pick_coord();
    case ($urandom_range(0, 7))
      0:       r.color = '0;
      1:       r.color = '1;
      default: r.color = 24'($urandom);
    endcase
    return r;
  endfunction

  function automatic lbpwf_pkg::in_item_t window_req(input logic [8:0] xs,
                                                     input logic [8:0] ys,
                                                     input logic [8:0] xe,
                                                     input logic [8:0] ye);
    lbpwf_pkg::in_item_t r;
    r           = rand_request();
    r.operation = lbpwf_pkg::OP_WINDOW;
    r.x_start   = xs;
    r.y_start   = ys;
    r.x_end     = xe;
    r.y_end     = ye;
    return r;
  endfunction

  function automatic lbpwf_pkg::in_item_t pixel_req(input logic [23:0] c);
    lbpwf_pkg::in_item_t r;
    r           = rand_request();
    r.operation = lbpwf_pkg::OP_PIXEL;
    r.color     = c;
    return r;
  endfunction

  task automatic send(input lbpwf_pkg::in_item_t r);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off the sender until every expected word is out, then let a
  // wordless pixel request finish too
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [2:0] bus, input logic [2:0] fmt,
                            input logic [2:0] xfer);
    logic [1:0] idx [3];
    logic [2:0] val [3];
    idx = '{lbpwf_pkg::CFG_BUS_IF, lbpwf_pkg::CFG_PIX_FMT, lbpwf_pkg::CFG_XFER_MODE};
    val = '{bus, fmt, xfer};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int sent;
    int n;
    sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: type I 8-bit bus, 16-bit pixels
    send(window_req('0, '0, '0, '0));
    send(window_req('1, '1, '1, '1));
    send(window_req(9'h155, 9'h0AA, 9'h100, 9'h0FF));
    send(pixel_req('0));
    send(pixel_req('1));
    send(pixel_req(24'hA5C3E7));
    wait_idle();

    // 16-bit bus, mode 0, 18-bit pixels: pixels give no words
    set_config(lbpwf_pkg::BUS_I16, 3'd1, {1'b0, lbpwf_pkg::XFER_M0});
    send(pixel_req('1));
    send(window_req('0, '1, '1, '0));
    wait_idle();

    // 9-bit buses in modes 2 and 3 with 18-bit pixels give no words
    set_config(lbpwf_pkg::BUS_I9, 3'd1, {1'b0, lbpwf_pkg::XFER_M2});
    send(pixel_req(24'h123456));
    wait_idle();
    set_config(lbpwf_pkg::BUS_I9, 3'd1, {1'b0, lbpwf_pkg::XFER_M3});
    send(pixel_req('1));
    wait_idle();
    set_config(lbpwf_pkg::BUS_II9, 3'd1, {1'b0, lbpwf_pkg::XFER_M3});
    send(pixel_req('1));
    wait_idle();
    set_config(lbpwf_pkg::BUS_II16, 3'd1, {1'b0, lbpwf_pkg::XFER_M0});
    send(pixel_req('1));
    wait_idle();

    // transfer mode has no effect on 8- and 18-bit buses
    set_config(lbpwf_pkg::BUS_II8, 3'd1, {1'b0, lbpwf_pkg::XFER_M3});
    send(window_req('1, '1, '1, '1));
    send(pixel_req('1));
    wait_idle();
    set_config(lbpwf_pkg::BUS_I18, 3'd1, {1'b0, lbpwf_pkg::XFER_M2});
    send(pixel_req(24'h5A5A5A));
    wait_idle();
    set_config(lbpwf_pkg::BUS_II18, 3'd0, {1'b0, lbpwf_pkg::XFER_M1});
    send(window_req('1, '0, '0, '1));
    send(pixel_req('1));
    wait_idle();
    set_config(lbpwf_pkg::BUS_II16, 3'd1, {1'b0, lbpwf_pkg::XFER_M3});
    send(pixel_req('1));
    send(pixel_req(24'h3C3C3C));
    wait_idle();

    while (sent < RANDOM_ITEMS) begin
      n       = $urandom_range(8, 24);
      no_idle = ($urandom_range(0, 4) == 0);
      set_config(3'($urandom), 3'($urandom), 3'($urandom));
      repeat (n) send(rand_request());
      wait_idle();
      sent += n;
    end

    no_idle = 1'b0;
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
